### rtl/core/cdb_pkg.sv
`default_nettype none

package cdb_pkg;

    // Q1.16 in 17 bits, 1.0 = 2**16
    localparam int unsigned VAL_W  = 17;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned NUM_CH = 3;

    // One restoring step per quotient bit
    localparam int unsigned DIV_STEPS = VAL_W;

    // Stage map: saturate, alpha scale, multiply, subtract, divider prep,
    // DIV_STEPS divider steps, output register
    localparam int unsigned ST_SAT     = 0;
    localparam int unsigned ST_ALPHA   = 1;
    localparam int unsigned ST_MUL     = 2;
    localparam int unsigned ST_SUB     = 3;
    localparam int unsigned ST_PREP    = 4;
    localparam int unsigned PRE_STAGES = ST_PREP + 1;
    localparam int unsigned NUM_STAGES = PRE_STAGES + DIV_STEPS + 1;
    localparam int unsigned ST_OUT     = NUM_STAGES - 1;

    typedef logic [VAL_W-1:0]              val_t;
    typedef logic [2*VAL_W-1:0]            prod_t;
    typedef logic [NUM_CH-1:0][VAL_W-1:0]  rgb_t;

    localparam val_t Q_ONE = val_t'(1 << FRAC_W);

    // One color channel inside the divider
    typedef struct packed {
        logic zero;   // base channel is zero
        logic sat;    // quotient known to reach or pass 1.0
        logic nbit;   // last nonzero dividend bit still to shift in
        val_t dvsr;
        val_t rem;
        val_t quo;
    } div_lane_t;

    typedef div_lane_t [NUM_CH-1:0] div_row_t;

    function automatic val_t sat_one(val_t v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

    // Q1.16 product, truncated
    function automatic val_t mul_q16(val_t a, val_t b);
        prod_t p;
        p = prod_t'(a) * prod_t'(b);
        return p[FRAC_W +: VAL_W];
    endfunction

endpackage

`default_nettype wire

### rtl/core/color_dodge_blend.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_*       in         s_valid / s_ready  factor, base RGBA, blend RGBA
// m_*       out        m_valid / m_ready  dodged RGB, base alpha
// cfg_*     in         cfg_we             alpha_scales_factor
//
// A transaction passes through 23 register stages: five front stages
// (saturate, alpha scale, multiply, subtract, divider prep), 17 restoring
// divider stages, one for each quotient bit, and the output register. One
// transaction enters per cycle while s_ready is high. Each stage holds
// while its successor is full and stalled, so bubbles are squeezed out and
// s_ready drops only when all 23 stages are full and m_ready is low.
// Reset clears the stage valid bits and the mode bit.

module color_dodge_blend (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic        cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [16:0] s_factor,
    input  logic [16:0] s_base_red,
    input  logic [16:0] s_base_green,
    input  logic [16:0] s_base_blue,
    input  logic [16:0] s_base_alpha,
    input  logic [16:0] s_blend_red,
    input  logic [16:0] s_blend_green,
    input  logic [16:0] s_blend_blue,
    input  logic [16:0] s_blend_alpha,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_out_red,
    output logic [16:0] m_out_green,
    output logic [16:0] m_out_blue,
    output logic [16:0] m_out_alpha
);

    localparam int unsigned NS = cdb_pkg::NUM_STAGES;
    localparam int unsigned NC = cdb_pkg::NUM_CH;
    localparam int unsigned DS = cdb_pkg::DIV_STEPS;

    logic                 mode_reg;
    logic [NS-1:0]        v_reg;
    logic [NS-1:0]        v_next;
    logic [NS-1:0]        adv;

    // saturate stage
    cdb_pkg::val_t        f0_reg, f0_next;
    cdb_pkg::val_t        ca0_reg, ca0_next;
    cdb_pkg::rgb_t        base0_reg, base0_next;
    cdb_pkg::rgb_t        blend0_reg, blend0_next;
    cdb_pkg::val_t        alpha0_reg;

    // alpha scale stage
    cdb_pkg::val_t        f1_reg, f1_next;
    cdb_pkg::rgb_t        base1_reg;
    cdb_pkg::rgb_t        blend1_reg;
    cdb_pkg::val_t        alpha1_reg;

    // multiply stage
    cdb_pkg::rgb_t        prod2_reg, prod2_next;
    cdb_pkg::rgb_t        base2_reg;
    cdb_pkg::val_t        alpha2_reg;

    // subtract stage
    cdb_pkg::rgb_t        dvsr3_reg, dvsr3_next;
    cdb_pkg::rgb_t        base3_reg;
    cdb_pkg::val_t        alpha3_reg;

    // divider prep and steps
    cdb_pkg::div_row_t    div_reg [DS+1];
    cdb_pkg::div_row_t    div_next [DS+1];
    cdb_pkg::val_t        dalpha_reg [DS+1];

    // output register
    cdb_pkg::rgb_t        out_reg, out_next;
    cdb_pkg::val_t        out_alpha_reg;

    // Advance a stage when it is empty or everything after it can move
    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_adv
            assign adv[gi] = m_ready || !(&v_reg[NS-1:gi]);
        end
    endgenerate

    assign s_ready = adv[cdb_pkg::ST_SAT];
    assign m_valid = v_reg[cdb_pkg::ST_OUT];

    // Move valid bits along with the data
    always_comb begin
        v_next = v_reg;
        if (adv[0]) begin
            v_next[0] = s_valid;
        end
        for (int i = 1; i < NS; i++) begin
            if (adv[i]) begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= '0;
            mode_reg <= 1'b0;
        end else begin
            v_reg <= v_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // Clamp inputs to 1.0
    always_comb begin
        f0_next        = cdb_pkg::sat_one(s_factor);
        ca0_next       = cdb_pkg::sat_one(s_blend_alpha);
        base0_next[0]  = cdb_pkg::sat_one(s_base_red);
        base0_next[1]  = cdb_pkg::sat_one(s_base_green);
        base0_next[2]  = cdb_pkg::sat_one(s_base_blue);
        blend0_next[0] = cdb_pkg::sat_one(s_blend_red);
        blend0_next[1] = cdb_pkg::sat_one(s_blend_green);
        blend0_next[2] = cdb_pkg::sat_one(s_blend_blue);
    end

    // Scale the factor by blend alpha when the mode is on
    always_comb begin
        f1_next = mode_reg ? cdb_pkg::mul_q16(f0_reg, ca0_reg) : f0_reg;
    end

    // Form factor * blend per channel
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            prod2_next[c] = cdb_pkg::mul_q16(f1_reg, blend1_reg[c]);
        end
    end

    // Divisor d = 1 - product; zero means full cancellation
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            dvsr3_next[c] = cdb_pkg::Q_ONE - prod2_reg[c];
        end
    end

    // Prep the divider: flag overflow (base >= 2d) and load base >> 1
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            div_next[0][c].zero = (base3_reg[c] == '0);
            div_next[0][c].sat  = ({1'b0, base3_reg[c]} >= {dvsr3_reg[c], 1'b0});
            div_next[0][c].nbit = base3_reg[c][0];
            div_next[0][c].dvsr = dvsr3_reg[c];
            div_next[0][c].rem  = {1'b0, base3_reg[c][cdb_pkg::VAL_W-1:1]};
            div_next[0][c].quo  = '0;
        end
    end

    // Front stage registers
    always_ff @(posedge aclk) begin
        if (adv[cdb_pkg::ST_SAT]) begin
            f0_reg     <= f0_next;
            ca0_reg    <= ca0_next;
            base0_reg  <= base0_next;
            blend0_reg <= blend0_next;
            alpha0_reg <= s_base_alpha;
        end
        if (adv[cdb_pkg::ST_ALPHA]) begin
            f1_reg     <= f1_next;
            base1_reg  <= base0_reg;
            blend1_reg <= blend0_reg;
            alpha1_reg <= alpha0_reg;
        end
        if (adv[cdb_pkg::ST_MUL]) begin
            prod2_reg  <= prod2_next;
            base2_reg  <= base1_reg;
            alpha2_reg <= alpha1_reg;
        end
        if (adv[cdb_pkg::ST_SUB]) begin
            dvsr3_reg  <= dvsr3_next;
            base3_reg  <= base2_reg;
            alpha3_reg <= alpha2_reg;
        end
        if (adv[cdb_pkg::ST_PREP]) begin
            div_reg[0]    <= div_next[0];
            dalpha_reg[0] <= alpha3_reg;
        end
    end

    // Restoring divider, one quotient bit per stage
    genvar gk;
    generate
        for (gk = 0; gk < DS; gk++) begin : g_div
            logic [NC-1:0][cdb_pkg::VAL_W:0] shifted;
            logic [NC-1:0]                   ge;

            always_comb begin
                for (int c = 0; c < NC; c++) begin
                    shifted[c] = {div_reg[gk][c].rem,
                                  (gk == 0) ? div_reg[gk][c].nbit : 1'b0};
                    ge[c] = (shifted[c] >= {1'b0, div_reg[gk][c].dvsr});
                    div_next[gk+1][c]     = div_reg[gk][c];
                    div_next[gk+1][c].rem = ge[c]
                        ? cdb_pkg::VAL_W'(shifted[c] - {1'b0, div_reg[gk][c].dvsr})
                        : shifted[c][cdb_pkg::VAL_W-1:0];
                    div_next[gk+1][c].quo = {div_reg[gk][c].quo[cdb_pkg::VAL_W-2:0],
                                             ge[c]};
                end
            end

            always_ff @(posedge aclk) begin
                if (adv[cdb_pkg::PRE_STAGES + gk]) begin
                    div_reg[gk+1]    <= div_next[gk+1];
                    dalpha_reg[gk+1] <= dalpha_reg[gk];
                end
            end
        end
    endgenerate

    // Resolve zero base and saturation
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            if (div_reg[DS][c].zero) begin
                out_next[c] = '0;
            end else if (div_reg[DS][c].sat || (div_reg[DS][c].quo > cdb_pkg::Q_ONE)) begin
                out_next[c] = cdb_pkg::Q_ONE;
            end else begin
                out_next[c] = div_reg[DS][c].quo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[cdb_pkg::ST_OUT]) begin
            out_reg       <= out_next;
            out_alpha_reg <= dalpha_reg[DS];
        end
    end

    assign m_out_red   = out_reg[0];
    assign m_out_green = out_reg[1];
    assign m_out_blue  = out_reg[2];
    assign m_out_alpha = out_alpha_reg;

    // Dodged channels never exceed 1.0
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_red <= cdb_pkg::Q_ONE) && (m_out_green <= cdb_pkg::Q_ONE)
                    && (m_out_blue <= cdb_pkg::Q_ONE))
        else $error("dodged channel above 1.0");

    // A cancelled divisor must be caught as saturation before the divider
    a_zero_dvsr: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[cdb_pkg::ST_PREP] |->
            (div_reg[0][0].dvsr != '0 || div_reg[0][0].sat) &&
            (div_reg[0][1].dvsr != '0 || div_reg[0][1].sat) &&
            (div_reg[0][2].dvsr != '0 || div_reg[0][2].sat))
        else $error("zero divisor without saturation flag");

    // Input stalls only when every stage holds a transaction
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&v_reg))
        else $error("input stalled with a bubble in the pipeline");

    // An accepted transaction lands in the first stage
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v_reg[cdb_pkg::ST_SAT])
        else $error("accepted transaction lost at pipeline entry");

endmodule

`default_nettype wire

### test/color_dodge_blend_tb.sv
`default_nettype none

module color_dodge_blend_tb;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned CHUNK_ITEMS  = 40;

    typedef struct packed {
        cdb_pkg::val_t factor;
        cdb_pkg::val_t base_red;
        cdb_pkg::val_t base_green;
        cdb_pkg::val_t base_blue;
        cdb_pkg::val_t base_alpha;
        cdb_pkg::val_t blend_red;
        cdb_pkg::val_t blend_green;
        cdb_pkg::val_t blend_blue;
        cdb_pkg::val_t blend_alpha;
    } pixel_t;

    typedef struct packed {
        cdb_pkg::val_t red;
        cdb_pkg::val_t green;
        cdb_pkg::val_t blue;
        cdb_pkg::val_t alpha;
    } dodge_px_t;

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;

    logic           s_valid       = 1'b0;
    logic           s_ready;
    cdb_pkg::val_t  s_factor      = '0;
    cdb_pkg::val_t  s_base_red    = '0;
    cdb_pkg::val_t  s_base_green  = '0;
    cdb_pkg::val_t  s_base_blue   = '0;
    cdb_pkg::val_t  s_base_alpha  = '0;
    cdb_pkg::val_t  s_blend_red   = '0;
    cdb_pkg::val_t  s_blend_green = '0;
    cdb_pkg::val_t  s_blend_blue  = '0;
    cdb_pkg::val_t  s_blend_alpha = '0;

    logic           m_valid;
    logic           m_ready = 1'b0;
    cdb_pkg::val_t  m_out_red;
    cdb_pkg::val_t  m_out_green;
    cdb_pkg::val_t  m_out_blue;
    cdb_pkg::val_t  m_out_alpha;

    // Testbench copy of the mode bit and pending dodge results
    bit         alpha_mode = 1'b0;
    dodge_px_t  dodge_expected_q[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit         src_burst  = 1'b0;
    bit         sink_burst = 1'b0;

    color_dodge_blend u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_factor      (s_factor),
        .s_base_red    (s_base_red),
        .s_base_green  (s_base_green),
        .s_base_blue   (s_base_blue),
        .s_base_alpha  (s_base_alpha),
        .s_blend_red   (s_blend_red),
        .s_blend_green (s_blend_green),
        .s_blend_blue  (s_blend_blue),
        .s_blend_alpha (s_blend_alpha),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_out_alpha   (m_out_alpha)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Dodge predictor
    // ------------------------------------------------------------------

    // Clamp a 17-bit value to 1.0
    function automatic cdb_pkg::val_t clamp_unit(cdb_pkg::val_t v);
        return (v > cdb_pkg::Q_ONE) ? cdb_pkg::Q_ONE : v;
    endfunction

    function automatic cdb_pkg::val_t dodge_lane(cdb_pkg::val_t f, cdb_pkg::val_t base,
                                                 cdb_pkg::val_t blend);
        logic [33:0] prod;
        logic [33:0] dvsr;
        logic [33:0] quo;
        if (base == '0)
            return '0;
        prod = (34'(f) * 34'(blend)) >> cdb_pkg::FRAC_W;
        // Divisor cancels out completely: channel goes to white
        if (prod >= 34'(cdb_pkg::Q_ONE))
            return cdb_pkg::Q_ONE;
        dvsr = 34'(cdb_pkg::Q_ONE) - prod;
        quo  = (34'(base) << cdb_pkg::FRAC_W) / dvsr;
        return (quo > 34'(cdb_pkg::Q_ONE)) ? cdb_pkg::Q_ONE : quo[cdb_pkg::VAL_W-1:0];
    endfunction

    function automatic dodge_px_t predict_dodge(pixel_t px, bit scale_by_alpha);
        dodge_px_t res;
        logic [33:0] scaled;
        cdb_pkg::val_t f;
        f = clamp_unit(px.factor);
        if (scale_by_alpha) begin
            scaled = (34'(f) * 34'(clamp_unit(px.blend_alpha))) >> cdb_pkg::FRAC_W;
            f = scaled[cdb_pkg::VAL_W-1:0];
        end
        res.red   = dodge_lane(f, clamp_unit(px.base_red),   clamp_unit(px.blend_red));
        res.green = dodge_lane(f, clamp_unit(px.base_green), clamp_unit(px.blend_green));
        res.blue  = dodge_lane(f, clamp_unit(px.base_blue),  clamp_unit(px.blend_blue));
        // Alpha passes through untouched, above-one values too
        res.alpha = px.base_alpha;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic pixel_t mk_pixel(cdb_pkg::val_t f, cdb_pkg::val_t br,
                                        cdb_pkg::val_t bg, cdb_pkg::val_t bb,
                                        cdb_pkg::val_t ba, cdb_pkg::val_t cr,
                                        cdb_pkg::val_t cg, cdb_pkg::val_t cb,
                                        cdb_pkg::val_t ca);
        pixel_t px;
        px.factor      = f;
        px.base_red    = br;
        px.base_green  = bg;
        px.base_blue   = bb;
        px.base_alpha  = ba;
        px.blend_red   = cr;
        px.blend_green = cg;
        px.blend_blue  = cb;
        px.blend_alpha = ca;
        return px;
    endfunction

    // Bias toward zero, one, near-one and small values to hit the corners
    function automatic cdb_pkg::val_t rand_chan();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return cdb_pkg::Q_ONE;
            2:       return cdb_pkg::val_t'($urandom_range(0, 131071));
            3:       return cdb_pkg::val_t'($urandom_range(1, 4096));
            4, 5:    return cdb_pkg::val_t'($urandom_range(61440, 65536));
            default: return cdb_pkg::val_t'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        return mk_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                        rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endfunction

    // Send one pixel transaction and record its expected result
    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        gap = src_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_factor      <= px.factor;
        s_base_red    <= px.base_red;
        s_base_green  <= px.base_green;
        s_base_blue   <= px.base_blue;
        s_base_alpha  <= px.base_alpha;
        s_blend_red   <= px.blend_red;
        s_blend_green <= px.blend_green;
        s_blend_blue  <= px.blend_blue;
        s_blend_alpha <= px.blend_alpha;
        do @(posedge aclk); while (!s_ready);
        dodge_expected_q.push_back(predict_dodge(px, alpha_mode));
    endtask

    // Drop valid and wait until the pipeline has emptied
    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (dodge_expected_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the mode bit; only called with the pipeline empty
    task automatic set_alpha_mode(input bit mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        alpha_mode = mode;
    endtask

    task automatic send_random_block(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            // Reshape the idle pattern every chunk, sometimes running flat out
            if (i % CHUNK_ITEMS == 0) begin
                src_burst  = ($urandom_range(0, 3) == 0);
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            send_pixel(rand_pixel());
        end
        src_burst  = 1'b0;
        sink_burst = 1'b0;
    endtask

    task automatic send_corner_set();
        // All zero
        send_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // No blend: divisor is one, base passes through
        send_pixel(mk_pixel(0, 65536, 32768, 1, 65536, 0, 0, 0, 65536));
        // Full divisor cancellation on every channel
        send_pixel(mk_pixel(65536, 1, 100, 65535, 7, 65536, 65536, 65536, 65536));
        // Zero base wins over full cancellation
        send_pixel(mk_pixel(65536, 0, 0, 0, 65536, 65536, 65536, 65536, 65536));
        // Every bit set: inputs above one saturate, alpha copied as is
        send_pixel(mk_pixel(131071, 131071, 131071, 131071, 131071,
                            131071, 131071, 131071, 131071));
        // Half divisor
        send_pixel(mk_pixel(32768, 16384, 32768, 40000, 12345, 65536, 65536, 65536, 65536));
        // Tiny divisor, quotient saturates on red and blue
        send_pixel(mk_pixel(65535, 65535, 1, 300, 65535, 65535, 65535, 65535, 65535));
        // Smallest nonzero values
        send_pixel(mk_pixel(1, 1, 1, 1, 1, 1, 1, 1, 1));
        // Just above one on every field
        send_pixel(mk_pixel(65537, 65537, 65537, 65537, 65537,
                            65537, 65537, 65537, 65537));
        // Divisor of one: quotient lands exactly on one, then beyond
        send_pixel(mk_pixel(65536, 1, 2, 65536, 65536, 65535, 65535, 65535, 65536));
        // Zero blend alpha
        send_pixel(mk_pixel(65536, 20000, 40000, 60000, 0, 50000, 65536, 10000, 0));
        // Half blend alpha, mixed channels
        send_pixel(mk_pixel(65536, 30000, 0, 65536, 98304, 65536, 32768, 1000, 32768));
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    initial begin : result_check
        int unsigned stall;
        dodge_px_t   got;
        dodge_px_t   want;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{m_out_red, m_out_green, m_out_blue, m_out_alpha};
            if (dodge_expected_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result r=%0d g=%0d b=%0d a=%0d",
                             got.red, got.green, got.blue, got.alpha);
            end else begin
                want = dodge_expected_q.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"mismatch: expected r=%0d g=%0d b=%0d a=%0d,",
                                  " got r=%0d g=%0d b=%0d a=%0d"},
                                 want.red, want.green, want.blue, want.alpha,
                                 got.red, got.green, got.blue, got.alpha);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Mode bit must come out of reset cleared
    task automatic test_reset_mode_corners();
        send_corner_set();
        drain_pipe();
    endtask

    task automatic test_alpha_mode_corners();
        set_alpha_mode(1'b1);
        send_corner_set();
        drain_pipe();
    endtask

    task automatic test_random_alpha_mode();
        set_alpha_mode(1'b1);
        send_random_block(600);
        drain_pipe();
    endtask

    task automatic test_random_plain_mode();
        set_alpha_mode(1'b0);
        send_random_block(600);
        drain_pipe();
    endtask

    // Flip the mode between short bursts of traffic
    task automatic test_mode_switching();
        for (int unsigned i = 0; i < 10; i++) begin
            set_alpha_mode(i[0]);
            send_random_block(60);
            drain_pipe();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_mode_corners();
        test_alpha_mode_corners();
        test_random_alpha_mode();
        test_random_plain_mode();
        test_mode_switching();

        // Catch stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && dodge_expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
